// File: rtl/core/cdc_pkg.sv
// cdc_pkg: shared types, codes and the month length table of the calendar date counter.
// No dependencies; imported by cdc_leap, cdc_step, calendar_date_counter and the testbench.

package cdc_pkg;

  localparam int unsigned MONTHS   = 12;
  localparam int unsigned CFG_BITS = 16;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_BACKUP  = 2'd2,
    ACT_COMPARE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_STORED_BAD = 2'd1,
    ST_GIVEN_BAD  = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  typedef struct packed {
    logic    date_valid;
    logic    earlier;
    status_t status;
  } step_res_t;

  localparam logic [4:0] MONTH_LEN [MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [3:0] MONTH_JAN    = 4'd1;
  localparam logic [3:0] MONTH_DEC    = 4'd12;
  localparam logic [4:0] DAY_FIRST    = 5'd1;
  localparam logic [4:0] DAY_DEC_LAST = 5'd31;

  // Days in month m (1..12); zero for a month number that means nothing.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      len = MONTH_LEN[4'(m - 4'd1)];
    end
    return len;
  endfunction

endpackage

// File: rtl/core/cdc_leap.sv
// cdc_leap: Gregorian leap-year test on a YEAR_BITS wide year.
// Divisibility by 25 via multiply by the modular inverse; depends on cdc_pkg.

module cdc_leap #(
  parameter int unsigned YEAR_BITS = 16
) (
  input  logic [YEAR_BITS-1:0] year,
  output logic                 leap
);
  import cdc_pkg::*;

  // Inverse of 25 modulo 2^64 by Newton steps (3, 6, 12, 24, 48, 96 bits).
  function automatic logic [63:0] inv25_calc();
    logic [63:0] x;
    x = 64'd25;
    for (int i = 0; i < 5; i++) begin
      x = x * (64'd2 - 64'd25 * x);
    end
    return x;
  endfunction

  localparam logic [63:0]          INV64 = inv25_calc();
  localparam logic [YEAR_BITS-1:0] INV   = INV64[YEAR_BITS-1:0];
  localparam logic [63:0]          LIM64 = ((64'd1 << YEAR_BITS) - 64'd1) / 64'd25;
  localparam logic [YEAR_BITS-1:0] LIM   = LIM64[YEAR_BITS-1:0];

  logic [YEAR_BITS-1:0] prod;
  logic                 div4;
  logic                 div16;
  logic                 div25;

  assign prod  = YEAR_BITS'(year * INV);
  assign div25 = (prod <= LIM);
  assign div4  = (year[1:0] == 2'd0);
  assign div16 = (year[3:0] == 4'd0);

  // by 4 and not by 100, or by 400 (= by 16 and by 25)
  assign leap = div4 && (!div25 || div16);

endmodule

// File: rtl/core/cdc_step.sv
// cdc_step: next stored date and result flags for one action.
// Depends on cdc_pkg and cdc_leap.

module cdc_step #(
  parameter int unsigned YEAR_BITS = 16
) (
  input  cdc_pkg::action_t               action,
  input  logic [YEAR_BITS-1:0]           year,
  input  logic [3:0]                     month,
  input  logic [4:0]                     day,
  input  logic                           in_leap,
  input  logic [YEAR_BITS-1:0]           stored_year,
  input  logic [3:0]                     stored_month,
  input  logic [4:0]                     stored_day,
  input  logic                           stored_valid,
  input  logic [cdc_pkg::CFG_BITS-1:0]   year_floor,
  output logic [YEAR_BITS-1:0]           year_next,
  output logic [3:0]                     month_next,
  output logic [4:0]                     day_next,
  output cdc_pkg::step_res_t             res
);
  import cdc_pkg::*;

  localparam int unsigned CW = (YEAR_BITS > CFG_BITS) ? YEAR_BITS : CFG_BITS;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

  logic                 st_leap;
  logic                 in_ok;
  logic [4:0]           cur_len;
  logic [4:0]           prev_len;
  logic [YEAR_BITS-1:0] year_dec;

  cdc_leap #(.YEAR_BITS(YEAR_BITS)) u_leap (
    .year (stored_year),
    .leap (st_leap)
  );

  assign in_ok = (CW'(year) >= CW'(year_floor)) &&
                 (month >= MONTH_JAN) && (month <= MONTH_DEC) &&
                 (day >= DAY_FIRST) && (day <= month_days(month, in_leap));

  assign cur_len  = month_days(stored_month, st_leap);
  assign prev_len = month_days(4'(stored_month - 4'd1), st_leap);
  assign year_dec = YEAR_BITS'(stored_year - 1'b1);

  always_comb begin
    year_next      = stored_year;
    month_next     = stored_month;
    day_next       = stored_day;
    res.date_valid = stored_valid;
    res.earlier    = 1'b0;
    res.status     = ST_OK;

    if (action == ACT_LOAD) begin
      year_next      = year;
      month_next     = month;
      day_next       = day;
      res.date_valid = in_ok;
      res.status     = in_ok ? ST_OK : ST_GIVEN_BAD;
    end else if (!stored_valid) begin
      res.status = ST_STORED_BAD;
    end else begin
      case (action)
        ACT_ADVANCE: begin
          if (stored_day < cur_len) begin
            day_next = 5'(stored_day + 5'd1);
          end else if (stored_month < MONTH_DEC) begin
            month_next = 4'(stored_month + 4'd1);
            day_next   = DAY_FIRST;
          end else if (stored_year == YEAR_MAX) begin
            res.status = ST_RANGE;
          end else begin
            year_next  = YEAR_BITS'(stored_year + 1'b1);
            month_next = MONTH_JAN;
            day_next   = DAY_FIRST;
          end
        end
        ACT_BACKUP: begin
          if (stored_day > DAY_FIRST) begin
            day_next = 5'(stored_day - 5'd1);
          end else if (stored_month > MONTH_JAN) begin
            month_next = 4'(stored_month - 4'd1);
            day_next   = prev_len;
          end else if (stored_year == '0 ||
                       CW'(year_dec) < CW'(year_floor)) begin
            res.status = ST_RANGE;
          end else begin
            year_next  = year_dec;
            month_next = MONTH_DEC;
            day_next   = DAY_DEC_LAST;
          end
        end
        ACT_COMPARE: begin
          if (!in_ok) begin
            res.status = ST_GIVEN_BAD;
          end else if (stored_year != year) begin
            res.earlier = stored_year < year;
          end else if (stored_month != month) begin
            res.earlier = stored_month < month;
          end else begin
            res.earlier = stored_day < day;
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/calendar_date_counter.sv
// calendar_date_counter: top level, input register, date state and result register.
// Depends on cdc_pkg, cdc_leap and cdc_step.
//
// Usage
//   Slave stream (s_*): one command per transfer. s_tuser carries the action
//   (load, advance, back up, compare); s_tdata carries year, month and day.
//   Master stream (m_*): exactly one result per command, in order: the
//   stored date after the step, its valid flag, the compare flag and status.
//   cfg_we/cfg_wdata write year_floor (earliest valid year); write only while
//   the block is idle (nothing in flight).
// Pipeline
//   A command is held in the input register, its result then in the result
//   register. One command per cycle while m_tready is high: the whole step
//   (leap test by one constant multiply, month length lookup, carry update)
//   sits in a single stage between the input register and the result register.
// Reset (rst, synchronous): stored date cleared to zero and marked invalid,
//   year_floor back to 1, both stream registers emptied.
// Back-pressure: while m_tready is low the result register holds, the input
//   register still takes one command, then s_tready drops until the result
//   is taken.

module calendar_date_counter #(
  parameter int unsigned YEAR_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_we,
  input  logic [cdc_pkg::CFG_BITS-1:0]           cfg_wdata,
  // command stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata, low bit up: year, month, day, zero fill
  input  logic [((YEAR_BITS+9+7)/8)*8-1:0]       s_tdata,
  // s_tuser: action
  input  logic [1:0]                             s_tuser,
  // result stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata, low bit up: cur_year, cur_month, cur_day, date_valid, earlier,
  // status, zero fill
  output logic [((YEAR_BITS+13+7)/8)*8-1:0]      m_tdata
);
  import cdc_pkg::*;

  localparam int unsigned OUT_W = ((YEAR_BITS + 13 + 7) / 8) * 8;

  // configuration register
  logic [CFG_BITS-1:0]  year_floor;

  // input register
  logic                 in_valid;
  action_t              in_action;
  logic [YEAR_BITS-1:0] in_year;
  logic [3:0]           in_month;
  logic [4:0]           in_day;
  logic                 in_leap;
  logic                 s_leap;

  // stored date
  logic [YEAR_BITS-1:0] stored_year;
  logic [3:0]           stored_month;
  logic [4:0]           stored_day;
  logic                 stored_valid;

  // step outputs
  logic [YEAR_BITS-1:0] year_next;
  logic [3:0]           month_next;
  logic [4:0]           day_next;
  step_res_t            res_next;

  // result register
  logic [YEAR_BITS-1:0] out_year;
  logic [3:0]           out_month;
  logic [4:0]           out_day;
  step_res_t            out_res;

  logic                 out_free;
  logic                 fire;

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // leap flag of the incoming year is taken with the command
  cdc_leap #(.YEAR_BITS(YEAR_BITS)) u_in_leap (
    .year (s_tdata[YEAR_BITS-1:0]),
    .leap (s_leap)
  );

  cdc_step #(.YEAR_BITS(YEAR_BITS)) u_step (
    .action           (in_action),
    .year             (in_year),
    .month            (in_month),
    .day              (in_day),
    .in_leap          (in_leap),
    .stored_year      (stored_year),
    .stored_month     (stored_month),
    .stored_day       (stored_day),
    .stored_valid     (stored_valid),
    .year_floor       (year_floor),
    .year_next        (year_next),
    .month_next       (month_next),
    .day_next         (day_next),
    .res              (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      year_floor <= CFG_BITS'(1);
    end else if (cfg_we) begin
      year_floor <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_action <= action_t'(s_tuser);
      in_year   <= s_tdata[YEAR_BITS-1:0];
      in_month  <= s_tdata[YEAR_BITS+3:YEAR_BITS];
      in_day    <= s_tdata[YEAR_BITS+8:YEAR_BITS+4];
      in_leap   <= s_leap;
    end
  end

  // stored date, updated as each command passes the step
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_year  <= '0;
      stored_month <= '0;
      stored_day   <= '0;
      stored_valid <= 1'b0;
    end else if (fire) begin
      stored_year  <= year_next;
      stored_month <= month_next;
      stored_day   <= day_next;
      stored_valid <= res_next.date_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (fire) begin
      out_year  <= year_next;
      out_month <= month_next;
      out_day   <= day_next;
      out_res   <= res_next;
    end
  end

  assign m_tdata = OUT_W'({out_res.status, out_res.earlier, out_res.date_valid,
                           out_day, out_month, out_year});

`ifndef SYNTHESIS
  // a valid stored date always has a sane month and day
  a_valid_date: assert property (@(posedge clk) disable iff (rst)
    stored_valid |-> (stored_month >= MONTH_JAN && stored_month <= MONTH_DEC &&
                      stored_day >= DAY_FIRST && stored_day <= DAY_DEC_LAST))
    else $error("stored date flagged valid but out of range");

  // a processed command always lands in the result register
  a_fire_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("result lost after step");

  // a range error (year overflow or backing up below the floor) leaves the stored date untouched
  a_range_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && res_next.status == ST_RANGE) |=>
      ($stable(stored_year) && $stable(stored_month) && $stable(stored_day)))
    else $error("date changed on out-of-range step");

  // earlier is only reported on a successful step
  a_earlier_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.earlier) |-> (out_res.status == ST_OK && out_res.date_valid))
    else $error("earlier set with failing status");

  // stored-invalid status never comes with a valid date
  a_invalid_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.status == ST_STORED_BAD) |-> !out_res.date_valid)
    else $error("stored-invalid status with valid date");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for calendar_date_counter (load, advance, back up, compare).
// Depends on cdc_pkg and the RTL; predicts untyped results in-bench, checks every result by field.

module testbench;
  import cdc_pkg::*;

  // Expected contents of one result transfer.
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        valid;
    logic        earlier;
    status_t     status;
  } date_res_t;

  // One row of the directed table; 'typed' rows carry a hand-written result.
  typedef struct packed {
    action_t     act;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        typed;
    date_res_t   want;
  } dir_row_t;

  localparam date_res_t NO_RES      = '0;
  localparam int        DIR_COUNT   = 26;
  localparam int        PHASES      = 5;
  localparam int        PHASE_ITEMS = 350;
  localparam int        DRAIN_WAIT  = 6;
  localparam int        HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int        MAX_PRINTS  = 40;

  // Directed part: reset state, field extremes, each action, every error code,
  // leap rules (400, 100, 4), month and year carries in both directions.
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    // anything before a load sees an invalid stored date
    '{ACT_COMPARE, 16'd2000,  4'd1,  5'd1,  1'b1,
      '{16'd0, 4'd0, 5'd0, 1'b0, 1'b0, ST_STORED_BAD}},
    '{ACT_BACKUP,  16'd65535, 4'd15, 5'd31, 1'b1,
      '{16'd0, 4'd0, 5'd0, 1'b0, 1'b0, ST_STORED_BAD}},
    // year zero is below the reset bound: stored, but flagged invalid
    '{ACT_LOAD,    16'd0,     4'd1,  5'd1,  1'b1,
      '{16'd0, 4'd1, 5'd1, 1'b0, 1'b0, ST_GIVEN_BAD}},
    '{ACT_LOAD,    16'd1,     4'd1,  5'd1,  1'b1,
      '{16'd1, 4'd1, 5'd1, 1'b1, 1'b0, ST_OK}},
    // backing up past the first valid year is refused
    '{ACT_BACKUP,  16'd0,     4'd0,  5'd0,  1'b1,
      '{16'd1, 4'd1, 5'd1, 1'b1, 1'b0, ST_RANGE}},
    '{ACT_LOAD,    16'd65535, 4'd12, 5'd31, 1'b1,
      '{16'd65535, 4'd12, 5'd31, 1'b1, 1'b0, ST_OK}},
    // year overflow is refused
    '{ACT_ADVANCE, 16'd0,     4'd0,  5'd0,  1'b1,
      '{16'd65535, 4'd12, 5'd31, 1'b1, 1'b0, ST_RANGE}},
    '{ACT_COMPARE, 16'd65535, 4'd12, 5'd31, 1'b1,
      '{16'd65535, 4'd12, 5'd31, 1'b1, 1'b0, ST_OK}},
    '{ACT_BACKUP,  16'd0,     4'd0,  5'd0,  1'b0, NO_RES},
    '{ACT_LOAD,    16'd2000,  4'd2,  5'd29, 1'b0, NO_RES},
    '{ACT_ADVANCE, 16'd0,     4'd0,  5'd0,  1'b0, NO_RES},
    '{ACT_BACKUP,  16'd0,     4'd0,  5'd0,  1'b0, NO_RES},
    // century year that is not a leap year
    '{ACT_LOAD,    16'd1900,  4'd2,  5'd29, 1'b1,
      '{16'd1900, 4'd2, 5'd29, 1'b0, 1'b0, ST_GIVEN_BAD}},
    '{ACT_ADVANCE, 16'd7,     4'd7,  5'd7,  1'b1,
      '{16'd1900, 4'd2, 5'd29, 1'b0, 1'b0, ST_STORED_BAD}},
    '{ACT_LOAD,    16'd2024,  4'd2,  5'd29, 1'b0, NO_RES},
    '{ACT_LOAD,    16'd2023,  4'd13, 5'd5,  1'b1,
      '{16'd2023, 4'd13, 5'd5, 1'b0, 1'b0, ST_GIVEN_BAD}},
    '{ACT_LOAD,    16'd2023,  4'd0,  5'd0,  1'b1,
      '{16'd2023, 4'd0, 5'd0, 1'b0, 1'b0, ST_GIVEN_BAD}},
    '{ACT_LOAD,    16'd2023,  4'd4,  5'd31, 1'b1,
      '{16'd2023, 4'd4, 5'd31, 1'b0, 1'b0, ST_GIVEN_BAD}},
    '{ACT_LOAD,    16'd2023,  4'd12, 5'd31, 1'b0, NO_RES},
    '{ACT_ADVANCE, 16'd0,     4'd0,  5'd0,  1'b0, NO_RES},
    '{ACT_BACKUP,  16'd0,     4'd0,  5'd0,  1'b0, NO_RES},
    '{ACT_COMPARE, 16'd2024,  4'd1,  5'd1,  1'b0, NO_RES},
    // compare against an impossible date
    '{ACT_COMPARE, 16'd2023,  4'd2,  5'd29, 1'b1,
      '{16'd2023, 4'd12, 5'd31, 1'b1, 1'b0, ST_GIVEN_BAD}},
    '{ACT_COMPARE, 16'd0,     4'd15, 5'd31, 1'b1,
      '{16'd2023, 4'd12, 5'd31, 1'b1, 1'b0, ST_GIVEN_BAD}},
    '{ACT_LOAD,    16'd2024,  4'd3,  5'd1,  1'b0, NO_RES},
    '{ACT_BACKUP,  16'd0,     4'd0,  5'd0,  1'b0, NO_RES}
  };

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = 32'd0;   // year, month, day, zero fill
  logic [1:0]  s_tuser   = 2'd0;    // action
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;             // cur_year, cur_month, cur_day, date_valid,
                                    // earlier, status, zero fill

  calendar_date_counter #(.YEAR_BITS(16)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Generous ceiling: worst-case gaps on both sides for every transfer is
  // well under a fifth of this.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: bench copy of the calendar state and the earliest valid year
  // ---------------------------------------------------------------------------
  logic [15:0] cal_year   = 16'd0;
  logic [3:0]  cal_month  = 4'd0;
  logic [4:0]  cal_day    = 5'd0;
  logic        cal_valid  = 1'b0;
  logic [15:0] min_year   = 16'd1;

  date_res_t   due_q [$];          // results still owed by the block
  int          items_sent   = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  bit          tx_calm      = 1'b0;
  logic        hold_off     = 1'b0;

  function automatic bit is_leap(input logic [15:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Month length; months outside 1..12 give 31 (only the generator asks).
  function automatic logic [4:0] days_in(input logic [15:0] y, input logic [3:0] m);
    case (m)
      4'd2:                     return is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  return 5'd30;
      default:                  return 5'd31;
    endcase
  endfunction

  function automatic bit date_ok(input logic [15:0] y, input logic [3:0] m,
                                 input logic [4:0] d);
    if (y < min_year) return 1'b0;
    if (m < 4'd1 || m > 4'd12) return 1'b0;
    return (d >= 5'd1) && (d <= days_in(y, m));
  endfunction

  // Apply one command to the bench state and return the result it must give.
  function automatic date_res_t predict_step(input action_t act, input logic [15:0] y,
                                             input logic [3:0] m, input logic [4:0] d);
    date_res_t r;
    r.earlier = 1'b0;
    r.status  = ST_OK;
    if (act == ACT_LOAD) begin
      // fields stored even when the date is rejected
      cal_year  = y;
      cal_month = m;
      cal_day   = d;
      cal_valid = date_ok(y, m, d);
      if (!cal_valid) r.status = ST_GIVEN_BAD;
    end else if (!cal_valid) begin
      r.status = ST_STORED_BAD;
    end else begin
      case (act)
        ACT_ADVANCE: begin
          if (cal_day < days_in(cal_year, cal_month)) begin
            cal_day = cal_day + 5'd1;
          end else if (cal_month < 4'd12) begin
            cal_month = cal_month + 4'd1;
            cal_day   = 5'd1;
          end else if (cal_year == 16'hFFFF) begin
            r.status = ST_RANGE;
          end else begin
            cal_year  = cal_year + 16'd1;
            cal_month = 4'd1;
            cal_day   = 5'd1;
          end
        end
        ACT_BACKUP: begin
          if (cal_day > 5'd1) begin
            cal_day = cal_day - 5'd1;
          end else if (cal_month > 4'd1) begin
            cal_month = cal_month - 4'd1;
            cal_day   = days_in(cal_year, cal_month);
          end else if (cal_year == 16'd0 || (cal_year - 16'd1) < min_year) begin
            r.status = ST_RANGE;
          end else begin
            cal_year  = cal_year - 16'd1;
            cal_month = 4'd12;
            cal_day   = 5'd31;
          end
        end
        default: begin
          if (!date_ok(y, m, d))    r.status  = ST_GIVEN_BAD;
          else if (cal_year != y)   r.earlier = cal_year < y;
          else if (cal_month != m)  r.earlier = cal_month < m;
          else                      r.earlier = cal_day < d;
        end
      endcase
    end
    r.year  = cal_year;
    r.month = cal_month;
    r.day   = cal_day;
    r.valid = cal_valid;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
  endtask

  task automatic check_result(input logic [31:0] w);
    date_res_t want;
    date_res_t got;
    got.year    = w[15:0];
    got.month   = w[19:16];
    got.day     = w[24:20];
    got.valid   = w[25];
    got.earlier = w[26];
    got.status  = status_t'(w[28:27]);
    if (due_q.size() == 0) begin
      report_mismatch("result transfer with nothing outstanding");
    end else begin
      want = due_q.pop_front();
      if (got.year != want.year)
        report_mismatch($sformatf("cur_year %0d, want %0d", got.year, want.year));
      if (got.month != want.month)
        report_mismatch($sformatf("cur_month %0d, want %0d", got.month, want.month));
      if (got.day != want.day)
        report_mismatch($sformatf("cur_day %0d, want %0d", got.day, want.day));
      if (got.valid != want.valid)
        report_mismatch($sformatf("date_valid %0b, want %0b", got.valid, want.valid));
      if (got.earlier != want.earlier)
        report_mismatch($sformatf("earlier %0b, want %0b", got.earlier, want.earlier));
      if (got.status != want.status)
        report_mismatch($sformatf("status %s, want %s", got.status.name(),
                                  want.status.name()));
    end
    results_seen++;
  endtask

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm)   return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: sample the transfer with pre-edge values, then choose the next
  // tready. Calm stretches have no stalls; hold_off is the long back-pressure.
  // ---------------------------------------------------------------------------
  int rx_wait   = 0;
  int rx_cycles = 0;
  bit rx_calm   = 1'b0;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles % 400 == 0) rx_calm <= ($urandom_range(0, 3) == 0);
    if (hold_off) begin
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait  <= rx_wait - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      rx_wait  <= pick_gap(rx_calm);
    end
  end

  // Long hold-off partway through: the sender keeps offering, so the block
  // fills its two registers and drops s_tready.
  initial begin
    while (items_sent < 600) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // One command transfer; the prediction is queued at the accepting edge.
  // tvalid stays high into the next command when no gap follows.
  task automatic send_cmd(input action_t act, input logic [15:0] y, input logic [3:0] m,
                          input logic [4:0] d, input logic typed, input date_res_t typed_res);
    date_res_t want;
    int        gap;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, d, m, y};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_step(act, y, m, d);
    if (typed) want = typed_res;
    due_q.push_back(want);
    items_sent++;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Years that matter: around the bound, the stored year, the top of the
  // range, zero, century years, and anything at all.
  function automatic logic [15:0] pick_year();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: return min_year + 16'($urandom_range(0, 3));
      5, 6, 7, 8:    return cal_year;
      9, 10:         return 16'hFFFF - 16'($urandom_range(0, 1));
      11:            return 16'd0;
      12:            return 16'd1600;
      13:            return 16'd1900;
      14:            return 16'd2000;
      15:            return 16'd2100;
      default:       return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed dates and stepping runs, a little noise.
  task automatic send_random();
    action_t     act;
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [4:0]  last;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      act = action_t'($urandom_range(0, 3));
      y   = 16'($urandom);
      m   = 4'($urandom);
      d   = 5'($urandom);
    end else begin
      if (!cal_valid && $urandom_range(0, 9) < 7) act = ACT_LOAD;
      else if (r < 18) act = ACT_LOAD;
      else if (r < 50) act = ACT_ADVANCE;
      else if (r < 78) act = ACT_BACKUP;
      else             act = ACT_COMPARE;
      y = pick_year();
      case ($urandom_range(0, 19))
        0, 1:    m = 4'($urandom);
        2, 3, 4: m = 4'd12;
        5, 6:    m = 4'd1;
        default: m = 4'($urandom_range(1, 12));
      endcase
      last = days_in(y, m);
      case ($urandom_range(0, 9))
        0, 1, 2: d = last;
        3, 4:    d = 5'd1;
        5:       d = 5'($urandom);
        default: d = 5'($urandom_range(1, last));
      endcase
      // compare close to the stored date half the time
      if (act == ACT_COMPARE && $urandom_range(0, 1) == 1) begin
        y = cal_year;
        m = cal_month;
        d = cal_day;
        case ($urandom_range(0, 6))
          0: y = y + 16'd1;
          1: y = y - 16'd1;
          2: m = m + 4'd1;
          3: m = m - 4'd1;
          4: d = d + 5'd1;
          5: d = d - 5'd1;
          default: ;
        endcase
      end
    end
    send_cmd(act, y, m, d, 1'b0, NO_RES);
  endtask

  // Register write with the block drained; the bench bound changes with it.
  task automatic set_first_year(input logic [15:0] v);
    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_year   = v;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases under several
  // bounds (zero, the top year, a historic year, a random one, back to one).
  // ---------------------------------------------------------------------------
  initial begin
    int          i;
    int          ph;
    int          n;
    logic [15:0] fy;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_COUNT; i++)
      send_cmd(DIR_ROWS[i].act, DIR_ROWS[i].year, DIR_ROWS[i].month, DIR_ROWS[i].day,
               DIR_ROWS[i].typed, DIR_ROWS[i].want);

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       fy = 16'd0;
        1:       fy = 16'hFFFF;
        2:       fy = 16'd1582;
        3:       fy = 16'($urandom_range(1, 3000));
        default: fy = 16'd1;
      endcase
      set_first_year(fy);
      // range edges under the new bound: earliest Jan 1 back, last Dec 31 on
      send_cmd(ACT_LOAD,    fy,       4'd1,  5'd1,  1'b0, NO_RES);
      send_cmd(ACT_BACKUP,  16'd0,    4'd0,  5'd0,  1'b0, NO_RES);
      send_cmd(ACT_LOAD,    16'hFFFF, 4'd12, 5'd31, 1'b0, NO_RES);
      send_cmd(ACT_ADVANCE, 16'd0,    4'd0,  5'd0,  1'b0, NO_RES);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        send_random();
      end
    end

    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
